// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands sampled on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication that must hold in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/dq_pkg.sv -----
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and codes for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

	typedef enum logic [1:0] {
		FUNC_PUSH_FRONT = 2'd0,
		FUNC_PUSH_BACK  = 2'd1,
		FUNC_POP_FRONT  = 2'd2,
		FUNC_POP_BACK   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STATUS_DONE  = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ACCESS,
		S_PRESENT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic access;
		logic present;
	} dq_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_busy;
	} dq_stat_t;

endpackage

// ----- src/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of 32-bit entries kept in a ring store.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Payload
//  in        in_valid / in_ready   func, entry_value
//  out       out_valid / out_ready popped_value, status, occupancy
//
//  An accepted transaction is captured, then the store access with the pointer
//  update is made, then the result is loaded into the output register.
//  The controller walks capture, store access and output load in turn and
//  takes no new transaction until the output load of the last one is done.
//  A stalled result holds the output register; the next transaction is still
//  accepted and waits before its own output load. Reset empties the queue.
// ----------------------------------------------------------------------------
module double_ended_queue #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic signed [31:0] entry_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] popped_value,
	output logic [1:0]         status,
	output logic [4:0]         occupancy
);
	import dq_pkg::*;

	dq_cmd_t  cmd;
	dq_stat_t stat;

	dq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dq_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.func         (func),
		.entry_value  (entry_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.popped_value (popped_value),
		.status       (status),
		.occupancy    (occupancy)
	);

endmodule

// ----- src/dq_ctrl.sv -----
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer: capture a transaction, update the ring, then present the result.
// ----------------------------------------------------------------------------
module dq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dq_pkg::dq_stat_t  stat,
	output dq_pkg::dq_cmd_t   cmd
);
	import dq_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd         = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_ACCESS;
				end
			end
			S_ACCESS: begin
				cmd.access = 1'b1;
				state_d    = S_PRESENT;
			end
			S_PRESENT: begin
				// Hold the finished result until the output register is free.
				if (!stat.out_busy) begin
					cmd.present = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- src/dq_dpath.sv -----
// ----------------------------------------------------------------------------
// dq_dpath
// Ring store, end pointers, occupancy count and output register.
// ----------------------------------------------------------------------------
module dq_dpath #(
	parameter int DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dq_pkg::dq_cmd_t     cmd,
	output dq_pkg::dq_stat_t    stat,
	input  logic [1:0]          func,
	input  logic signed [31:0]  entry_value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  popped_value,
	output logic [1:0]          status,
	output logic [4:0]          occupancy
);
	import dq_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	func_t          func_q;
	logic [31:0]    value_q;
	logic [PW-1:0]  front_q;
	logic [PW-1:0]  back_q;
	logic [CW-1:0]  count_q;
	status_t        result_q;
	logic           pop_ok_q;
	logic [31:0]    rd_data_q;
	logic [31:0]    mem [DEPTH];

	logic           out_valid_q;
	logic [31:0]    popped_q;
	logic [1:0]     status_q;
	logic [4:0]     occ_q;

	logic           is_push;
	logic           is_full;
	logic           is_empty;
	logic           mem_we;
	logic           mem_re;
	logic [PW-1:0]  wr_addr;
	logic [PW-1:0]  rd_addr;
	logic [PW-1:0]  front_d;
	logic [PW-1:0]  back_d;
	logic [CW-1:0]  count_d;
	status_t        result_d;

	function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] idx);
		return (idx == PW'(DEPTH - 1)) ? '0 : idx + PW'(1);
	endfunction

	function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] idx);
		return (idx == '0) ? PW'(DEPTH - 1) : idx - PW'(1);
	endfunction

	assign is_push  = (func_q == FUNC_PUSH_FRONT) || (func_q == FUNC_PUSH_BACK);
	assign is_full  = (count_q == CW'(DEPTH));
	assign is_empty = (count_q == '0);

	always_comb begin
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		wr_addr  = back_q;
		rd_addr  = front_q;
		front_d  = front_q;
		back_d   = back_q;
		count_d  = count_q;
		result_d = STATUS_DONE;
		if (is_push && is_full) begin
			result_d = STATUS_FULL;
		end else if (!is_push && is_empty) begin
			result_d = STATUS_EMPTY;
		end else begin
			case (func_q)
				FUNC_PUSH_FRONT: begin
					front_d = ring_prev(front_q);
					wr_addr = ring_prev(front_q);
					mem_we  = 1'b1;
					count_d = count_q + CW'(1);
				end
				FUNC_PUSH_BACK: begin
					wr_addr = back_q;
					back_d  = ring_next(back_q);
					mem_we  = 1'b1;
					count_d = count_q + CW'(1);
				end
				FUNC_POP_FRONT: begin
					rd_addr = front_q;
					front_d = ring_next(front_q);
					mem_re  = 1'b1;
					count_d = count_q - CW'(1);
				end
				default: begin
					// Back pointer sits one past the back entry.
					rd_addr = ring_prev(back_q);
					back_d  = ring_prev(back_q);
					mem_re  = 1'b1;
					count_d = count_q - CW'(1);
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q  <= func_t'(func);
			value_q <= entry_value;
		end
		if (cmd.access) begin
			result_q <= result_d;
			pop_ok_q <= mem_re;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.access && mem_we) begin
			mem[wr_addr] <= value_q;
		end
		if (cmd.access && mem_re) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
		end else if (cmd.access) begin
			front_q <= front_d;
			back_q  <= back_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.present) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.present) begin
			popped_q <= pop_ok_q ? rd_data_q : '0;
			status_q <= result_q;
			occ_q    <= 5'(count_q);
		end
	end

	assign stat.out_busy = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign popped_value  = popped_q;
	assign status        = status_q;
	assign occupancy     = occ_q;

endmodule

// ----- src/dq_checker.sv -----
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks on the input handshake and result transactions of the queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dq_checker #(
	parameter int DEPTH = 16
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] popped_value,
	input logic [1:0]         status,
	input logic [4:0]         occupancy
);
	import dq_pkg::*;

	logic        in_txn;
	logic        out_stall;
	logic        out_fail;
	logic        out_empty;
	logic        out_full;
	logic        fail_ok;
	logic [38:0] out_word;

	assign in_txn    = in_valid && in_ready;
	assign out_stall = out_valid && !out_ready;
	assign out_fail  = out_valid && (status != STATUS_DONE);
	assign out_empty = out_valid && (status == STATUS_EMPTY);
	assign out_full  = out_valid && (status == STATUS_FULL);
	assign fail_ok   = (popped_value == '0)
		&& (status == STATUS_EMPTY || status == STATUS_FULL);
	assign out_word  = {popped_value, status, occupancy};

	`ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word), "result changed while stalled")

	`ASSERT_SAME(a_fail_zero, out_fail, fail_ok, "failed transaction with bad value or status")

	`ASSERT_SAME(a_empty_occ, out_empty, occupancy == '0, "empty status with nonzero occupancy")

	`ASSERT_SAME(a_full_occ, out_full, occupancy == 5'(DEPTH), "full status without full occupancy")

	`ASSERT_NEXT(a_accept_idle, in_txn, !in_ready, "transaction accepted on consecutive cycles")

endmodule

bind double_ended_queue dq_checker #(.DEPTH(DEPTH)) u_dq_checker (.*);
